@@ src/frs_pkg.sv @@
// Shared constants, types and position codes for the framed packet receiver.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package frs_pkg;

    // Frame buffer depth and the widths that follow from it.
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int TOT_W     = 9;

    localparam logic [TOT_W-1:0] FRAME_OVERHEAD = TOT_W'(6);
    localparam logic [TOT_W-1:0] DEPTH_TOT      = TOT_W'(BUF_DEPTH);
    localparam logic [7:0]       MARKER_RESET   = 8'hFF;

    // Byte positions inside a frame with a fixed meaning.
    localparam logic [ADDR_W-1:0] POS_MARK0 = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] POS_MARK1 = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] POS_ID    = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] POS_LEN   = ADDR_W'(3);

    // Input beat kinds carried in tuser.
    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic  we;
        t_addr addr;
        logic [7:0] data;
    } t_store_wr;

    typedef struct packed {
        logic  re;
        t_addr addr;
    } t_store_rd;

    typedef struct packed {
        logic read_en;
        logic read_ok;
        logic frame_end;
        logic frame_good;
        logic frame_ready;
    } t_result;

endpackage

@@ src/frs_store.sv @@
// Frame byte buffer: one write port, one read port with registered data.
// Depends on frs_pkg.
`timescale 1ns / 1ps

module frs_store (
    input  logic               i_clk,
    input  frs_pkg::t_store_wr i_wr,
    input  frs_pkg::t_store_rd i_rd,
    output logic [7:0]         o_rd_data
);
    import frs_pkg::*;

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/frs_ctrl.sv @@
// Frame tracking state: position, expected length, running checksum, ready flag.
// Drives the buffer ports and the per-beat result flags. Depends on frs_pkg.
`timescale 1ns / 1ps

module frs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_accept,
    input  logic               i_action,
    input  logic [7:0]         i_rx_byte,
    input  logic [5:0]         i_read_offset,
    output frs_pkg::t_store_wr o_wr,
    output frs_pkg::t_store_rd o_rd,
    output frs_pkg::t_result   o_res
);
    import frs_pkg::*;

    logic [7:0]       r_marker;
    t_addr            r_pos,   n_pos;
    logic [TOT_W-1:0] r_exp,   n_exp;
    logic [15:0]      r_sum,   n_sum;
    logic             r_ready, n_ready;
    logic [7:0]       r_prev;
    logic [7:0]       r_len;

    logic             frame_end;
    logic             frame_good;
    logic [TOT_W-1:0] pos_w;
    logic [TOT_W-1:0] pos_inc;
    logic [TOT_W-1:0] rd_idx;
    logic [TOT_W-1:0] rd_total;
    logic             rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_exp   <= '0;
            r_sum   <= '0;
            r_ready <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_exp   <= n_exp;
            r_sum   <= n_sum;
            r_ready <= n_ready;
        end
    end

    // The previous byte is the checksum high byte when a frame closes, and the
    // length byte mirrors buffer entry three so reads need only one port.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_action == ACT_RX) begin
            r_prev <= i_rx_byte;
            if (r_pos == POS_LEN) begin
                r_len <= i_rx_byte;
            end
        end
    end

    assign pos_w = TOT_W'(r_pos);

    always_comb begin
        n_pos      = r_pos;
        n_exp      = r_exp;
        n_sum      = r_sum;
        n_ready    = r_ready;
        frame_end  = 1'b0;
        frame_good = 1'b0;
        pos_inc    = pos_w + TOT_W'(1);

        if (i_accept && i_action == ACT_RX) begin
            n_ready = 1'b0;
            if (r_pos == POS_MARK0) begin
                if (i_rx_byte == r_marker) begin
                    n_exp = FRAME_OVERHEAD;
                end
            end else if (r_pos == POS_MARK1) begin
                if (i_rx_byte != r_marker) begin
                    n_exp = '0;
                    n_pos = '0;
                end
            end else if (r_pos == POS_LEN) begin
                n_exp = r_exp + TOT_W'(i_rx_byte);
                if (n_exp > DEPTH_TOT) begin
                    n_exp = '0;
                    n_pos = '0;
                end
            end

            if (n_exp != '0) begin
                if (r_pos == POS_ID) begin
                    n_sum = 16'(i_rx_byte);
                end else if (r_pos > POS_ID && (pos_w + TOT_W'(2)) < n_exp) begin
                    n_sum = r_sum + 16'(i_rx_byte);
                end

                if (pos_inc == n_exp) begin
                    frame_end = 1'b1;
                    if ({r_prev, i_rx_byte} == n_sum) begin
                        frame_good = 1'b1;
                        n_ready    = 1'b1;
                    end
                    n_exp = '0;
                    n_pos = '0;
                end else begin
                    n_pos = pos_inc[ADDR_W-1:0];
                end
            end
        end
    end

    assign rd_idx   = TOT_W'(i_read_offset) + TOT_W'(2);
    assign rd_total = TOT_W'(r_len) + FRAME_OVERHEAD;
    assign rd_hit   = r_ready && (rd_idx < rd_total) && (rd_idx < DEPTH_TOT);

    assign o_wr.we   = i_accept && i_action == ACT_RX;
    assign o_wr.addr = r_pos;
    assign o_wr.data = i_rx_byte;

    assign o_rd.re   = i_accept && i_action == ACT_READ && rd_hit;
    assign o_rd.addr = rd_idx[ADDR_W-1:0];

    always_comb begin
        o_res = '0;
        if (i_action == ACT_READ) begin
            o_res.read_en     = rd_hit;
            o_res.read_ok     = r_ready;
            o_res.frame_ready = r_ready;
        end else begin
            o_res.frame_end   = frame_end;
            o_res.frame_good  = frame_good;
            o_res.frame_ready = n_ready;
        end
    end

endmodule

@@ src/frame_receiver_sum16_check_top.sv @@
// Top level of the marker-framed packet receiver with a 16-bit additive checksum.
// Depends on frs_pkg, frs_store and frs_ctrl.
`timescale 1ns / 1ps

// The block takes one beat per clock unless the output stalls, and returns
// exactly one result beat for each, from its output register. A receive beat
// (tuser low) feeds one byte of the link: the block hunts for two marker bytes,
// then stores the id, the length byte, the payload and a big-endian checksum in
// its frame buffer, summing id, length and payload as the bytes arrive. The
// result flags a completed frame and whether its checksum matched; a good frame
// raises the ready flag, and any later received byte lowers it again. A frame
// whose total length (length plus six) exceeds the buffer depth is dropped at
// the length byte. A read beat (tuser high) returns the stored byte at the given
// offset from the id byte, zero when it lies beyond the frame, and read_ok shows
// whether a validated frame is present. The rate of one beat per cycle rests on
// the update of position and checksum from each accepted byte and on the
// registered buffer read data being covered by one pipeline stage ahead of the
// output register. The marker byte resets to 0xFF and should be changed only
// while no beat is in flight.
module frame_receiver_sum16_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // marker_byte

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,     // rx_byte[7:0], read_offset[13:8], zero
    input  logic        s_axis_tuser,     // action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata      // read_data[7:0], read_ok, frame_end,
                                          // frame_good, frame_ready, zero
);
    import frs_pkg::*;

    logic       accept;
    logic       s1_go;
    t_store_wr  wr;
    t_store_rd  rd;
    t_result    res;
    logic [7:0] rd_data;

    logic        r_s1_valid;
    t_result     r_s1_res;
    logic        r_out_valid;
    logic [15:0] r_out_tdata;

    // Stage one advances whenever the output register is empty or being drained.
    // The buffer read data is held while stage one waits because the read port
    // is enabled only when a beat is accepted.
    assign s1_go         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    frs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_action      (s_axis_tuser),
        .i_rx_byte     (s_axis_tdata[7:0]),
        .i_read_offset (s_axis_tdata[13:8]),
        .o_wr          (wr),
        .o_rd          (rd),
        .o_res         (res)
    );

    frs_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= res;
        end
        if (s1_go && r_s1_valid) begin
            r_out_tdata <= {4'b0000,
                            r_s1_res.frame_ready,
                            r_s1_res.frame_good,
                            r_s1_res.frame_end,
                            r_s1_res.read_ok,
                            r_s1_res.read_en ? rd_data : 8'h00};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule
